// ===== design/iie_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iie_pkg
// Shared types, constants and helpers of the infix expression evaluator.
// ----------------------------------------------------------------------------
package iie_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int PTR_W       = $clog2(STACK_DEPTH);
   localparam int CNT_W       = PTR_W + 1;
   localparam int STEP_W      = $clog2(VALUE_WIDTH);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Character codes.
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;

   // Character class of a token.
   typedef enum logic [2:0] {
      CLS_ADD   = 3'd0,
      CLS_SUB   = 3'd1,
      CLS_MUL   = 3'd2,
      CLS_DIV   = 3'd3,
      CLS_OPEN  = 3'd4,
      CLS_CLOSE = 3'd5,
      CLS_OTHER = 3'd6
   } cls_type;

   // Operator stack entries.
   typedef enum logic [2:0] {
      OP_ADD      = 3'd0,
      OP_SUB      = 3'd1,
      OP_MUL      = 3'd2,
      OP_DIV      = 3'd3,
      OP_OPEN     = 3'd4,
      OP_OPEN_MUL = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      KIND_NONE     = 2'd0,
      KIND_OPERAND  = 2'd1,
      KIND_OPERATOR = 2'd2,
      KIND_OPEN     = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_PAREN     = 3'd1,
      ST_OPERAND   = 3'd2,
      ST_DIV_ZERO  = 3'd3,
      ST_OVERFLOW  = 3'd4
   } status_type;

   // Token handed from the front end to the execution side.
   typedef struct packed {
      logic                   num_valid;
      logic [VALUE_WIDTH-1:0] num;
      cls_type                cls;
      logic                   eot;
   } token_type;

   // Queue status seen by both sides.
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic logic is_high_prec(op_type op);
      return !(op == OP_ADD || op == OP_SUB);
   endfunction

   function automatic op_type cls_to_op(cls_type c);
      op_type r;
      unique case (c)
         CLS_ADD: r = OP_ADD;
         CLS_SUB: r = OP_SUB;
         CLS_MUL: r = OP_MUL;
         default: r = OP_DIV;
      endcase
      return r;
   endfunction

endpackage

// ===== design/iie_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iie_if
// Valid/ready channels for character requests and evaluation results.
// ----------------------------------------------------------------------------
interface iie_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_text;
   modport source (output valid, char_code, end_of_text, input ready);
   modport sink   (input valid, char_code, end_of_text, output ready);
endinterface

interface iie_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] expr_value;
   logic [2:0]         status_code;
   modport source (output valid, expr_value, status_code, input ready);
   modport sink   (input valid, expr_value, status_code, output ready);
endinterface

// ===== design/infix_integer_expression_evaluator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_integer_expression_evaluator
// Streaming evaluator of infix integer expressions, one character a request.
// ----------------------------------------------------------------------------
// The front end takes one character a cycle while its four-entry token queue
// has room; digits never reach the execution side unless they end the text.
// Every other character becomes a token that the execution sequencer
// handles one at a time, reducing each operator with add, subtract or
// multiply, or for a division with the one-bit-per-cycle divider. An implied
// multiplication closed by ')' is applied when the parenthesis closes.
// The end of text adds the final reduction before the result appears in the
// output register; expr_value is zero whenever status_code is not zero.
module infix_integer_expression_evaluator
   import iie_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   iie_req_if.sink   req_bus,
   iie_rsp_if.source rsp_bus
);

   logic      q_push, q_pop;
   token_type push_tok, head_tok;
   qstat_type qs;

   iie_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .qs    (qs),
      .push  (q_push),
      .tok   (push_tok)
   );

   iie_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_tok (push_tok),
      .pop      (q_pop),
      .head_tok (head_tok),
      .qs       (qs)
   );

   iie_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_tok (head_tok),
      .qs       (qs),
      .pop      (q_pop),
      .rsp      (rsp_bus)
   );

   // The queue is never written when full nor read when empty.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (!qs.full || q_pop))
      else $error("token queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !qs.empty)
      else $error("token queue read while empty");

   // A failed evaluation reports a zero value.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.status_code != ST_OK) |-> (rsp_bus.expr_value == 0))
      else $error("nonzero value with error status");

   // A new result only loads when the previous one has gone.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |=> rsp_bus.valid && $stable(rsp_bus.expr_value))
      else $error("result dropped while stalled");

endmodule

// ===== design/iie_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iie_fifo
// Short token queue between the front end and the execution side.
// ----------------------------------------------------------------------------
module iie_fifo
   import iie_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  token_type push_tok,
   input  logic      pop,
   output token_type head_tok,
   output qstat_type qs
);

   token_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]       cnt_ff, cnt_in;

   // Pointer and fill count update.
   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Storage carries no reset.
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_tok;
   end

   assign head_tok = slot_ff[rd_ff];
   assign qs.full  = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign qs.empty = (cnt_ff == '0);

endmodule

// ===== design/iie_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iie_front
// Accepts characters, builds decimal literals and emits classified tokens.
// ----------------------------------------------------------------------------
module iie_front
   import iie_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   iie_req_if.sink   req,
   input  qstat_type qs,
   output logic      push,
   output token_type tok
);

   logic [VALUE_WIDTH-1:0] acc_ff, acc_in, acc_next;
   logic                   innum_ff, innum_in;
   logic                   accept, is_digit;
   logic [VALUE_WIDTH-1:0] base;

   assign req.ready = !qs.full;
   assign accept    = req.valid && req.ready;
   assign is_digit  = (req.char_code >= CH_ZERO) && (req.char_code <= CH_NINE);

   // Literal accumulation: acc * 10 + digit, wrapping.
   always_comb begin
      base     = innum_ff ? acc_ff : '0;
      acc_next = (base << 3) + (base << 1)
               + VALUE_WIDTH'(req.char_code - CH_ZERO);
   end

   // Token formation: a digit only makes a token when it ends the text.
   always_comb begin
      tok.eot       = req.end_of_text;
      tok.num_valid = is_digit || innum_ff;
      tok.num       = is_digit ? acc_next : acc_ff;
      unique case (req.char_code)
         CH_PLUS:  tok.cls = CLS_ADD;
         CH_MINUS: tok.cls = CLS_SUB;
         CH_STAR:  tok.cls = CLS_MUL;
         CH_SLASH: tok.cls = CLS_DIV;
         CH_OPEN:  tok.cls = CLS_OPEN;
         CH_CLOSE: tok.cls = CLS_CLOSE;
         default:  tok.cls = CLS_OTHER;
      endcase
      push = accept && (!is_digit || req.end_of_text);
   end

   always_comb begin
      acc_in   = acc_ff;
      innum_in = innum_ff;
      if (accept) begin
         if (is_digit && !req.end_of_text) begin
            acc_in   = acc_next;
            innum_in = 1'b1;
         end else begin
            acc_in   = '0;
            innum_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         innum_ff <= 1'b0;
         acc_ff   <= '0;
      end else begin
         innum_ff <= innum_in;
         acc_ff   <= acc_in;
      end
   end

endmodule

// ===== design/iie_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iie_div
// Iterative signed divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module iie_div
   import iie_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [VALUE_WIDTH-1:0] dividend,
   input  logic [VALUE_WIDTH-1:0] divisor,
   output logic                   done,
   output logic [VALUE_WIDTH-1:0] quotient
);

   logic                   busy_ff, busy_in, done_ff, done_in, neg_ff, neg_in;
   logic [STEP_W-1:0]      cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in, quo_ff, quo_in, mb_ff, mb_in;
   logic [VALUE_WIDTH:0]   rem_sh;
   logic [VALUE_WIDTH+1:0] trial;
   logic                   na, nb;

   assign na = dividend[VALUE_WIDTH-1];
   assign nb = divisor[VALUE_WIDTH-1];

   // One restoring step per cycle.
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[VALUE_WIDTH-1]};
      trial   = {1'b0, rem_sh} - {2'b00, mb_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      mb_in   = mb_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = na ? -dividend : dividend;
         mb_in   = nb ? -divisor : divisor;
         neg_in  = na ^ nb;
      end else if (busy_ff) begin
         if (!trial[VALUE_WIDTH+1]) begin
            rem_in = trial[VALUE_WIDTH-1:0];
            quo_in = {quo_ff[VALUE_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[VALUE_WIDTH-1:0];
            quo_in = {quo_ff[VALUE_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(VALUE_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      mb_ff  <= mb_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -quo_ff : quo_ff;

endmodule

// ===== design/iie_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iie_back
// Execution side: operator and value stacks, reduction and result register.
// ----------------------------------------------------------------------------
module iie_back
   import iie_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  token_type head_tok,
   input  qstat_type qs,
   output logic      pop,
   iie_rsp_if.source rsp
);

   typedef enum logic [17:0] {
      S_IDLE      = 18'd1 << 0,
      S_PUSH_NUM  = 18'd1 << 1,
      S_DISPATCH  = 18'd1 << 2,
      S_RED_RD    = 18'd1 << 3,
      S_RED_CHK   = 18'd1 << 4,
      S_AP_START  = 18'd1 << 5,
      S_AP_RA     = 18'd1 << 6,
      S_AP_WAIT   = 18'd1 << 7,
      S_AP_EXEC   = 18'd1 << 8,
      S_AP_DIV    = 18'd1 << 9,
      S_AP_PUSH   = 18'd1 << 10,
      S_OP_PUSH   = 18'd1 << 11,
      S_CLOSE_POP = 18'd1 << 12,
      S_CLOSE_TOP = 18'd1 << 13,
      S_FIN       = 18'd1 << 14,
      S_EOT_START = 18'd1 << 15,
      S_EOT_VCHK  = 18'd1 << 16,
      S_EOT_OUT   = 18'd1 << 17
   } state_type;

   // Where a reduction continues when it stops.
   typedef enum logic [1:0] {
      RET_OP    = 2'd0,
      RET_CLOSE = 2'd1,
      RET_EOT   = 2'd2
   } ret_type;

   state_type              state_ff, state_in;
   token_type              tok_ff, tok_in;
   logic [CNT_W-1:0]       ocount_ff, ocount_in, vcount_ff, vcount_in, paren_ff, paren_in;
   kind_type               prev_ff, prev_in;
   status_type             err_ff, err_in;
   logic                   minh_ff, minh_in, apclose_ff, apclose_in;
   ret_type                ret_ff, ret_in;
   op_type                 apop_ff, apop_in;
   logic [VALUE_WIDTH-1:0] a_ff, a_in, b_ff, b_in, r_ff, r_in;
   logic                   rv_ff, rv_in;
   logic [VALUE_WIDTH-1:0] rval_ff, rval_in;
   status_type             rst_ff, rst_in;

   logic [VALUE_WIDTH-1:0] vmem [STACK_DEPTH];
   op_type                 omem [STACK_DEPTH];
   logic [VALUE_WIDTH-1:0] vrd_ff, vwdata;
   op_type                 ord_ff, owdata;
   logic [PTR_W-1:0]       vraddr, vwaddr, oraddr, owaddr;
   logic                   vwe, owe;
   logic                   div_start, div_done, out_free;
   logic [VALUE_WIDTH-1:0] div_q;

   iie_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (a_ff),
      .divisor  (b_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign out_free = !rv_ff || rsp.ready;

   // Sequencer for one token at a time.
   always_comb begin
      state_in   = state_ff;
      tok_in     = tok_ff;
      ocount_in  = ocount_ff;
      vcount_in  = vcount_ff;
      paren_in   = paren_ff;
      prev_in    = prev_ff;
      err_in     = err_ff;
      minh_in    = minh_ff;
      apclose_in = apclose_ff;
      ret_in     = ret_ff;
      apop_in    = apop_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      r_in       = r_ff;
      rv_in      = rv_ff && !rsp.ready;
      rval_in    = rval_ff;
      rst_in     = rst_ff;
      pop        = 1'b0;
      div_start  = 1'b0;
      vwe        = 1'b0;
      owe        = 1'b0;
      vwaddr     = PTR_W'(vcount_ff);
      vwdata     = r_ff;
      owaddr     = PTR_W'(ocount_ff);
      owdata     = cls_to_op(tok_ff.cls);
      vraddr     = PTR_W'(vcount_ff - 1'b1);
      oraddr     = PTR_W'(ocount_ff - 1'b1);

      unique case (state_ff)
         S_IDLE: begin
            if (!qs.empty) begin
               pop    = 1'b1;
               tok_in = head_tok;
               if (err_ff != ST_OK)          state_in = S_FIN;
               else if (head_tok.num_valid)  state_in = S_PUSH_NUM;
               else                          state_in = S_DISPATCH;
            end
         end
         S_PUSH_NUM: begin
            if (vcount_ff >= CNT_W'(STACK_DEPTH)) begin
               err_in = ST_OVERFLOW;
            end else begin
               vwe       = 1'b1;
               vwdata    = tok_ff.num;
               vcount_in = vcount_ff + 1'b1;
            end
            prev_in  = KIND_OPERAND;
            state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            state_in = S_FIN;
            if (err_ff == ST_OK) begin
               unique case (tok_ff.cls)
                  CLS_ADD, CLS_SUB, CLS_MUL, CLS_DIV: begin
                     minh_in  = is_high_prec(cls_to_op(tok_ff.cls));
                     ret_in   = RET_OP;
                     state_in = S_RED_RD;
                  end
                  CLS_OPEN: begin
                     if (ocount_ff >= CNT_W'(STACK_DEPTH)) begin
                        err_in = ST_OVERFLOW;
                     end else begin
                        owe       = 1'b1;
                        owdata    = (prev_ff == KIND_OPERAND) ? OP_OPEN_MUL : OP_OPEN;
                        ocount_in = ocount_ff + 1'b1;
                        paren_in  = paren_ff + 1'b1;
                        prev_in   = KIND_OPEN;
                     end
                  end
                  CLS_CLOSE: begin
                     if (paren_ff == '0) begin
                        err_in = ST_PAREN;
                     end else begin
                        minh_in  = 1'b0;
                        ret_in   = RET_CLOSE;
                        state_in = S_RED_RD;
                     end
                  end
                  default: state_in = S_FIN;
               endcase
            end
         end
         // Reduction: read the top operator, then decide.
         S_RED_RD: begin
            if (ocount_ff == '0 || err_ff != ST_OK) begin
               unique case (ret_ff)
                  RET_OP:    state_in = S_OP_PUSH;
                  RET_CLOSE: state_in = S_CLOSE_POP;
                  default:   state_in = S_EOT_VCHK;
               endcase
            end else begin
               state_in = S_RED_CHK;
            end
         end
         S_RED_CHK: begin
            if (ord_ff == OP_OPEN || ord_ff == OP_OPEN_MUL
                || (!is_high_prec(ord_ff) && minh_ff)) begin
               unique case (ret_ff)
                  RET_OP:    state_in = S_OP_PUSH;
                  RET_CLOSE: state_in = S_CLOSE_POP;
                  default:   state_in = S_EOT_VCHK;
               endcase
            end else begin
               ocount_in  = ocount_ff - 1'b1;
               apop_in    = ord_ff;
               apclose_in = 1'b0;
               state_in   = S_AP_START;
            end
         end
         // Apply one operator to the two top values.
         S_AP_START: begin
            if (vcount_ff < CNT_W'(2)) begin
               err_in   = ST_OPERAND;
               state_in = apclose_ff ? S_FIN : S_RED_RD;
            end else begin
               state_in = S_AP_RA;
            end
         end
         S_AP_RA: begin
            b_in     = vrd_ff;
            vraddr   = PTR_W'(vcount_ff - CNT_W'(2));
            state_in = S_AP_WAIT;
         end
         S_AP_WAIT: begin
            a_in      = vrd_ff;
            vcount_in = vcount_ff - CNT_W'(2);
            state_in  = S_AP_EXEC;
         end
         S_AP_EXEC: begin
            state_in = S_AP_PUSH;
            unique case (apop_ff)
               OP_ADD: r_in = a_ff + b_ff;
               OP_SUB: r_in = a_ff - b_ff;
               OP_MUL: r_in = VALUE_WIDTH'(a_ff * b_ff);
               default: begin
                  if (b_ff == '0) begin
                     err_in   = ST_DIV_ZERO;
                     state_in = apclose_ff ? S_FIN : S_RED_RD;
                  end else begin
                     div_start = 1'b1;
                     state_in  = S_AP_DIV;
                  end
               end
            endcase
         end
         S_AP_DIV: begin
            if (div_done) begin
               r_in     = div_q;
               state_in = S_AP_PUSH;
            end
         end
         S_AP_PUSH: begin
            vwe       = 1'b1;
            vcount_in = vcount_ff + 1'b1;
            state_in  = apclose_ff ? S_FIN : S_RED_RD;
         end
         S_OP_PUSH: begin
            if (err_ff == ST_OK) begin
               if (ocount_ff >= CNT_W'(STACK_DEPTH)) begin
                  err_in = ST_OVERFLOW;
               end else begin
                  owe       = 1'b1;
                  ocount_in = ocount_ff + 1'b1;
                  prev_in   = KIND_OPERATOR;
               end
            end
            state_in = S_FIN;
         end
         S_CLOSE_POP: begin
            if (err_ff != ST_OK || ocount_ff == '0) state_in = S_FIN;
            else                                    state_in = S_CLOSE_TOP;
         end
         S_CLOSE_TOP: begin
            ocount_in = ocount_ff - 1'b1;
            paren_in  = paren_ff - 1'b1;
            prev_in   = KIND_OPERAND;
            if (ord_ff == OP_OPEN_MUL) begin
               apop_in    = OP_MUL;
               apclose_in = 1'b1;
               state_in   = S_AP_START;
            end else begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            state_in = tok_ff.eot ? S_EOT_START : S_IDLE;
         end
         // End of text: close checks, final reduction, result.
         S_EOT_START: begin
            if (err_ff != ST_OK) begin
               state_in = S_EOT_OUT;
            end else if (paren_ff != '0) begin
               err_in   = ST_PAREN;
               state_in = S_EOT_OUT;
            end else begin
               minh_in  = 1'b0;
               ret_in   = RET_EOT;
               state_in = S_RED_RD;
            end
         end
         S_EOT_VCHK: begin
            if (err_ff == ST_OK && vcount_ff == '0) err_in = ST_OPERAND;
            state_in = S_EOT_OUT;
         end
         S_EOT_OUT: begin
            if (out_free) begin
               rv_in     = 1'b1;
               rval_in   = (err_ff == ST_OK) ? vrd_ff : '0;
               rst_in    = err_ff;
               ocount_in = '0;
               vcount_in = '0;
               paren_in  = '0;
               prev_in   = KIND_NONE;
               err_in    = ST_OK;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ocount_ff <= '0;
         vcount_ff <= '0;
         paren_ff  <= '0;
         prev_ff   <= KIND_NONE;
         err_ff    <= ST_OK;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ocount_ff <= ocount_in;
         vcount_ff <= vcount_in;
         paren_ff  <= paren_in;
         prev_ff   <= prev_in;
         err_ff    <= err_in;
         rv_ff     <= rv_in;
      end
      tok_ff     <= tok_in;
      minh_ff    <= minh_in;
      apclose_ff <= apclose_in;
      ret_ff     <= ret_in;
      apop_ff    <= apop_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      r_ff       <= r_in;
      rval_ff    <= rval_in;
      rst_ff     <= rst_in;
   end

   // Stack memories with registered reads.
   always_ff @(posedge clock) begin
      if (vwe) vmem[vwaddr] <= vwdata;
      if (owe) omem[owaddr] <= owdata;
      vrd_ff <= vmem[vraddr];
      ord_ff <= omem[oraddr];
   end

   assign rsp.valid       = rv_ff;
   assign rsp.expr_value  = rval_ff;
   assign rsp.status_code = rst_ff;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the streaming infix expression evaluator.
// ----------------------------------------------------------------------------
// Characters are sent in bursts with random gaps while the result side stalls
// on its own pattern. A behavioral evaluator in this module computes the
// value and status that each end-of-text request must return, and every
// result is compared field by field with the oldest pending prediction.
module tb;
   import iie_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int MAX_REPORTS    = 10;

   typedef struct {
      logic [7:0]  ch;
      logic        eot;
      logic        has_exp;
      logic [31:0] exp_value;
      status_type  exp_status;
   } stim_row_type;

   typedef struct {
      logic [31:0] value;
      status_type  status;
   } eval_result_type;

   logic clock;
   logic reset;

   iie_req_if req_bus ();
   iie_rsp_if rsp_bus ();

   infix_integer_expression_evaluator dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Evaluator state mirrored from the block's behavior.
   op_type      ops [STACK_DEPTH];
   int          op_cnt;
   logic [31:0] vals [STACK_DEPTH];
   int          val_cnt;
   logic [31:0] accum;
   bit          in_num;
   kind_type    prev_kind;
   int          open_cnt;
   status_type  err;

   eval_result_type results_due[$];
   stim_row_type    stim_rows[$];
   int              mismatches;
   bit              failed;

   function automatic int prec_of(op_type op);
      return (op == OP_ADD || op == OP_SUB) ? 1 : 2;
   endfunction

   function automatic void clear_eval();
      op_cnt    = 0;
      val_cnt   = 0;
      accum     = '0;
      in_num    = 0;
      prev_kind = KIND_NONE;
      open_cnt  = 0;
      err       = ST_OK;
   endfunction

   function automatic void flag(status_type code);
      if (err == ST_OK) err = code;
   endfunction

   function automatic void push_val(logic [31:0] v);
      if (val_cnt >= STACK_DEPTH) flag(ST_OVERFLOW);
      else begin
         vals[val_cnt] = v;
         val_cnt++;
      end
   endfunction

   function automatic void do_op(op_type op);
      logic signed [31:0] a, b;
      logic [31:0] r;
      logic [31:0] ma, mb, q;
      if (val_cnt < 2) begin
         flag(ST_OPERAND);
         return;
      end
      b = vals[val_cnt-1];
      a = vals[val_cnt-2];
      val_cnt -= 2;
      case (op)
         OP_ADD: r = a + b;
         OP_SUB: r = a - b;
         OP_MUL: r = a * b;
         default: begin
            if (b == 0) begin
               flag(ST_DIV_ZERO);
               return;
            end
            // Truncating division done on magnitudes so that the most
            // negative value over -1 wraps instead of trapping.
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            q  = ma / mb;
            r  = (a[31] != b[31]) ? -q : q;
         end
      endcase
      push_val(r);
   endfunction

   function automatic void reduce_ops(int min_prec);
      while (op_cnt > 0 && err == ST_OK) begin
         if (ops[op_cnt-1] inside {OP_OPEN, OP_OPEN_MUL} ||
             prec_of(ops[op_cnt-1]) < min_prec) break;
         op_cnt--;
         do_op(ops[op_cnt]);
      end
   endfunction

   function automatic void close_number();
      if (in_num) begin
         in_num = 0;
         push_val(accum);
         accum     = '0;
         prev_kind = KIND_OPERAND;
      end
   endfunction

   function automatic bit push_op(op_type op);
      if (op_cnt >= STACK_DEPTH) begin
         flag(ST_OVERFLOW);
         return 0;
      end
      ops[op_cnt] = op;
      op_cnt++;
      return 1;
   endfunction

   function automatic void take_char(logic [7:0] c);
      op_type op;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         if (!in_num) begin
            in_num = 1;
            accum  = '0;
         end
         accum = accum * 10 + (c - CH_ZERO);
         return;
      end
      close_number();
      if (err != ST_OK) return;
      if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) begin
         op = (c == CH_PLUS) ? OP_ADD : (c == CH_MINUS) ? OP_SUB :
              (c == CH_STAR) ? OP_MUL : OP_DIV;
         reduce_ops(prec_of(op));
         if (err != ST_OK) return;
         if (push_op(op)) prev_kind = KIND_OPERATOR;
      end else if (c == CH_OPEN) begin
         op = (prev_kind == KIND_OPERAND) ? OP_OPEN_MUL : OP_OPEN;
         if (push_op(op)) begin
            open_cnt++;
            prev_kind = KIND_OPEN;
         end
      end else if (c == CH_CLOSE) begin
         if (open_cnt == 0) begin
            flag(ST_PAREN);
            return;
         end
         reduce_ops(1);
         if (err != ST_OK || op_cnt == 0) return;
         op_cnt--;
         op = ops[op_cnt];
         open_cnt--;
         if (op == OP_OPEN_MUL) do_op(OP_MUL);
         prev_kind = KIND_OPERAND;
      end
   endfunction

   // Returns 1 and fills res when the character ends the expression.
   function automatic bit eval_char(logic [7:0] c, logic eot, output eval_result_type res);
      res.value  = '0;
      res.status = ST_OK;
      if (err == ST_OK) take_char(c);
      if (!eot) return 0;
      if (err == ST_OK) close_number();
      if (err == ST_OK && open_cnt != 0) flag(ST_PAREN);
      if (err == ST_OK) reduce_ops(1);
      if (err == ST_OK && val_cnt == 0) flag(ST_OPERAND);
      if (err == ST_OK) res.value = vals[val_cnt-1];
      res.status = err;
      clear_eval();
      return 1;
   endfunction

   // Clock.
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Stimulus building.
   function automatic void add_row(logic [7:0] c, logic e, bit has = 0,
                                   logic [31:0] v = 0, status_type s = ST_OK);
      stim_row_type r;
      r.ch = c; r.eot = e; r.has_exp = has; r.exp_value = v; r.exp_status = s;
      stim_rows.push_back(r);
   endfunction

   function automatic void add_text(string s, bit has = 0, logic [31:0] v = 0,
                                    status_type st = ST_OK);
      for (int i = 0; i < s.len(); i++)
         add_row(s[i], i == s.len() - 1, has && i == s.len() - 1, v, st);
   endfunction

   function automatic string rand_operand(int depth);
      int k;
      k = $urandom_range(0, 9);
      if (depth < 3 && k < 2)
         return {"(", rand_expr(depth + 1), ")"};
      if (k == 2) return $sformatf("%0d", $urandom);
      return $sformatf("%0d", $urandom_range(0, 99));
   endfunction

   function automatic string rand_expr(int depth);
      string s;
      string opch;
      int n;
      s = rand_operand(depth);
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 4))
            0: opch = "+";
            1: opch = "-";
            2: opch = "*";
            3: opch = "/";
            default: opch = " ";
         endcase
         if (opch == " " && $urandom_range(0, 1)) opch = "";
         s = {s, opch, rand_operand(depth)};
      end
      return s;
   endfunction

   function automatic void build_stimulus();
      string s;
      // Directed cases with results that can be read at a glance.
      add_text("0", 1, 32'd0, ST_OK);
      add_text("2147483647", 1, 32'h7FFFFFFF, ST_OK);
      add_text("4294967295", 1, 32'hFFFFFFFF, ST_OK);
      add_text("1+2*3", 1, 32'd7, ST_OK);
      add_text("7-3-2", 1, 32'd2, ST_OK);
      add_text("2(3+4)", 1, 32'd14, ST_OK);
      add_text("-7/2", 1, 32'd0, ST_OPERAND);
      add_text("0-7/2");
      add_text("1 2", 1, 32'd2, ST_OK);
      add_text("1)", 1, 32'd0, ST_PAREN);
      add_text("(1", 1, 32'd0, ST_PAREN);
      add_text("5/0", 1, 32'd0, ST_DIV_ZERO);
      add_text("(0-2147483647-1)/(0-1)");
      // Seventeen opening parentheses overflow the operator stack.
      add_text({"((((((((", "((((((((", "(1"}, 1, 32'd0, ST_OVERFLOW);
      // Seventeen literals overflow the value stack.
      add_text({"1 1 1 1 1 1 1 1 ", "1 1 1 1 1 1 1 1 ", "1"}, 1, 32'd0, ST_OVERFLOW);
      add_row(8'h20, 1, 1, 32'd0, ST_OPERAND);
      add_row(8'hFF, 0); add_row(8'h80, 0); add_text("3#4*(2)x");
      // Random well-formed expressions with some noise and broken ones.
      while (stim_rows.size() < 480) begin
         s = rand_expr(0);
         if ($urandom_range(0, 9) == 0) s = {s, ")"};
         if ($urandom_range(0, 9) == 0) s = {"(", s};
         if ($urandom_range(0, 9) == 0) begin
            add_row(8'($urandom_range(0, 255)), 0);
         end
         add_text(s);
      end
      for (int i = 0; i < 20; i++) add_row(8'($urandom_range(0, 255)), i == 19);
   endfunction

   // Sender: bursts with random gaps.
   int idle_cycles;

   initial begin
      eval_result_type res;
      int burst;
      reset               = 1;
      req_bus.valid       <= 0;
      req_bus.char_code   <= '0;
      req_bus.end_of_text <= 0;
      clear_eval();
      mismatches = 0;
      failed     = 0;
      build_stimulus();
      repeat (2) @(posedge clock);
      reset <= 0;
      burst = $urandom_range(1, 20);
      foreach (stim_rows[i]) begin
         if (burst == 0) begin
            req_bus.valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst = $urandom_range(1, 20);
         end
         req_bus.valid       <= 1;
         req_bus.char_code   <= stim_rows[i].ch;
         req_bus.end_of_text <= stim_rows[i].eot;
         @(posedge clock);
         while (!req_bus.ready) @(posedge clock);
         if (eval_char(stim_rows[i].ch, stim_rows[i].eot, res)) begin
            if (stim_rows[i].has_exp &&
                (res.value != stim_rows[i].exp_value ||
                 res.status != stim_rows[i].exp_status)) begin
               $display("table row %0d disagrees with evaluator", i);
               failed = 1;
            end
            results_due.push_back(res);
         end
         burst--;
      end
      req_bus.valid <= 0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (!failed && mismatches == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   // Receiver stall pattern.
   logic [7:0] stall_lfsr;
   always @(posedge clock) begin
      if (reset) begin
         stall_lfsr    <= 8'hA5;
         rsp_bus.ready <= 0;
      end else begin
         stall_lfsr    <= {stall_lfsr[6:0],
                           stall_lfsr[7] ^ stall_lfsr[5] ^ stall_lfsr[4] ^ stall_lfsr[3]};
         rsp_bus.ready <= (stall_lfsr[2:0] != 3'd0) || ($urandom_range(0, 3) == 0);
      end
   end
   initial rsp_bus.ready = 0;

   // Result checking.
   always @(posedge clock) begin
      eval_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (results_due.size() == 0) begin
            failed = 1;
            if (mismatches < MAX_REPORTS)
               $display("unexpected result value=%0d status=%0d",
                        rsp_bus.expr_value, rsp_bus.status_code);
            mismatches++;
         end else begin
            want = results_due.pop_front();
            if (rsp_bus.expr_value !== want.value ||
                rsp_bus.status_code !== want.status) begin
               if (mismatches < MAX_REPORTS)
                  $display("mismatch: value exp %0d got %0d, status exp %0d got %0d",
                           $signed(want.value), rsp_bus.expr_value,
                           want.status, rsp_bus.status_code);
               mismatches++;
            end
         end
      end
   end

   // Watchdog on cycles with no accepted request or result.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

endmodule

// ===== sim.f =====
design/iie_pkg.sv
design/iie_if.sv
design/iie_fifo.sv
design/iie_front.sv
design/iie_div.sv
design/iie_back.sv
design/infix_integer_expression_evaluator.sv
sim/tb.sv
